// ===== sv/imrot_pkg.sv =====
package imrot_pkg;

  // Image geometry.
  localparam int IMAGE_WIDTH  = 160;
  localparam int IMAGE_HEIGHT = 128;
  localparam int STORE_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;

  localparam int COL_W  = $clog2(IMAGE_WIDTH);
  localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Rotation centre, halves rounded down.
  localparam int CX = IMAGE_WIDTH / 2;
  localparam int CY = IMAGE_HEIGHT / 2;

  // Arithmetic widths.
  localparam int PIX_W  = 16;
  localparam int COEF_W = 12;
  localparam int FRAC_W = 10;
  localparam int CRD_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
  localparam int PROD_W = CRD_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SH_W   = SUM_W - FRAC_W;
  localparam int XF_W   = SH_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [COEF_W-1:0] SINE_RESET   = COEF_W'(0);
  localparam logic signed [COEF_W-1:0] COSINE_RESET = COEF_W'(1024);
  localparam logic        [PIX_W-1:0]  FILL_RESET   = 16'hFFFF;

  // Output queue.
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_OUTPUT = 1'b1
  } imrot_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SINE   = 2'd0,
    REG_COSINE = 2'd1,
    REG_FILL   = 2'd2
  } imrot_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] sine;
    logic signed [COEF_W-1:0] cosine;
    logic        [PIX_W-1:0]  fill;
  } imrot_cfg_t;

  // One store access, issued by the mapper to the image store.
  typedef struct packed {
    logic              valid;
    logic              is_load;
    logic              in_image;
    logic              eof;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
  } imrot_acc_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eof;
  } imrot_res_t;

endpackage

// ===== sv/imrot_if.sv =====
interface imrot_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [imrot_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output action, output pixel_value, input ready);
  modport sink   (input valid, input action, input pixel_value, output ready);
endinterface

interface imrot_out_if;
  logic                       valid;
  logic                       ready;
  logic [imrot_pkg::PIX_W-1:0] out_pixel;
  logic                       end_of_frame;

  modport source (output valid, output out_pixel, output end_of_frame, input ready);
  modport sink   (input valid, input out_pixel, input end_of_frame, output ready);
endinterface

interface imrot_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [imrot_pkg::CFG_IDX_W-1:0]  index;
  logic [imrot_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/imrot_cfg_regs.sv =====
module imrot_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [imrot_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [imrot_pkg::CFG_DATA_W-1:0] wr_data_i,
  output imrot_pkg::imrot_cfg_t               cfg_o
);

  imrot_pkg::imrot_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (imrot_pkg::imrot_reg_e'(wr_idx_i))
        imrot_pkg::REG_SINE: begin
          cfg_d.sine = wr_data_i[imrot_pkg::COEF_W-1:0];
        end
        imrot_pkg::REG_COSINE: begin
          cfg_d.cosine = wr_data_i[imrot_pkg::COEF_W-1:0];
        end
        imrot_pkg::REG_FILL: begin
          cfg_d.fill = wr_data_i[imrot_pkg::PIX_W-1:0];
        end
        default: begin
          // Writes to unused indexes are dropped.
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sine   <= imrot_pkg::SINE_RESET;
      cfg_q.cosine <= imrot_pkg::COSINE_RESET;
      cfg_q.fill   <= imrot_pkg::FILL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/imrot_mapper.sv =====
module imrot_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           action_i,
  input  logic [imrot_pkg::PIX_W-1:0]    pixel_i,
  input  imrot_pkg::imrot_cfg_t          cfg_i,
  output imrot_pkg::imrot_acc_t          acc_o
);

  localparam int COL_W  = imrot_pkg::COL_W;
  localparam int ROW_W  = imrot_pkg::ROW_W;
  localparam int ADDR_W = imrot_pkg::ADDR_W;
  localparam int CRD_W  = imrot_pkg::CRD_W;
  localparam int PROD_W = imrot_pkg::PROD_W;
  localparam int SUM_W  = imrot_pkg::SUM_W;
  localparam int SH_W   = imrot_pkg::SH_W;
  localparam int XF_W   = imrot_pkg::XF_W;
  localparam int FRAC_W = imrot_pkg::FRAC_W;

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(imrot_pkg::IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(imrot_pkg::IMAGE_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] LOAD_LAST = ADDR_W'(imrot_pkg::STORE_DEPTH - 1);
  localparam logic signed [XF_W-1:0] CX_S = XF_W'(imrot_pkg::CX);
  localparam logic signed [XF_W-1:0] CY_S = XF_W'(imrot_pkg::CY);
  localparam logic signed [XF_W-1:0] W_S  = XF_W'(imrot_pkg::IMAGE_WIDTH);
  localparam logic signed [XF_W-1:0] H_S  = XF_W'(imrot_pkg::IMAGE_HEIGHT);

  logic [COL_W-1:0]  col_d, col_q;
  logic [ROW_W-1:0]  row_d, row_q;
  logic [ADDR_W-1:0] lpos_d, lpos_q;
  logic              is_req, is_load;

  logic signed [CRD_W-1:0]  xm, ym;
  logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;

  // Stage one: products.
  logic                     s1_valid_q, s1_load_q, s1_eof_q;
  logic [imrot_pkg::PIX_W-1:0] s1_pixel_q;
  logic [ADDR_W-1:0]        s1_laddr_q;
  logic signed [PROD_W-1:0] s1_xc_q, s1_ys_q, s1_xs_q, s1_yc_q;

  // Stage two: source coordinate and address.
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [SH_W-1:0]  xs, ys;
  logic signed [XF_W-1:0]  xf, yf;
  logic                    in_image;
  logic [ADDR_W-1:0]       raddr;
  imrot_pkg::imrot_acc_t   acc_d, acc_q;

  assign is_req  = accept_i && (action_i == imrot_pkg::ACT_OUTPUT);
  assign is_load = accept_i && (action_i == imrot_pkg::ACT_LOAD);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    lpos_d = lpos_q;
    if (is_req) begin
      if (col_q == COL_LAST) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    if (is_load) begin
      lpos_d = (lpos_q == LOAD_LAST) ? '0 : lpos_q + ADDR_W'(1);
    end
  end

  // Offsets from the centre; the subtraction wraps into the signed result.
  assign xm = CRD_W'(col_q) - CRD_W'(imrot_pkg::CX);
  assign ym = CRD_W'(row_q) - CRD_W'(imrot_pkg::CY);

  assign p_xc = PROD_W'(xm) * PROD_W'(cfg_i.cosine);
  assign p_ys = PROD_W'(ym) * PROD_W'(cfg_i.sine);
  assign p_xs = PROD_W'(xm) * PROD_W'(cfg_i.sine);
  assign p_yc = PROD_W'(ym) * PROD_W'(cfg_i.cosine);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      lpos_q     <= '0;
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      lpos_q     <= lpos_d;
      s1_valid_q <= accept_i;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_load_q  <= is_load;
    s1_eof_q   <= is_req && (col_q == COL_LAST) && (row_q == ROW_LAST);
    s1_pixel_q <= pixel_i;
    s1_laddr_q <= lpos_q;
    s1_xc_q    <= p_xc;
    s1_ys_q    <= p_ys;
    s1_xs_q    <= p_xs;
    s1_yc_q    <= p_yc;
  end

  // The shift right of the exact sum is a floor division by 1024.
  assign sx = SUM_W'(s1_xc_q) - SUM_W'(s1_ys_q);
  assign sy = SUM_W'(s1_xs_q) + SUM_W'(s1_yc_q);
  assign xs = sx[SUM_W-1:FRAC_W];
  assign ys = sy[SUM_W-1:FRAC_W];
  assign xf = XF_W'(xs) + CX_S;
  assign yf = XF_W'(ys) + CY_S;

  // Column and row zero count as outside.
  assign in_image = (xf > 0) && (xf < W_S) && (yf > 0) && (yf < H_S);
  assign raddr    = ADDR_W'(yf[ROW_W-1:0]) * ADDR_W'(imrot_pkg::IMAGE_WIDTH)
                  + ADDR_W'(xf[COL_W-1:0]);

  always_comb begin
    acc_d.valid    = s1_valid_q;
    acc_d.is_load  = s1_load_q;
    acc_d.in_image = in_image && !s1_load_q;
    acc_d.eof      = s1_eof_q;
    acc_d.addr     = s1_load_q ? s1_laddr_q : raddr;
    acc_d.pixel    = s1_pixel_q;
  end

  assign acc_o = acc_q;

`ifndef ASSERT_OFF
  // A read address must fall within the image.
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q.valid && acc_q.in_image |-> 32'(acc_q.addr) < imrot_pkg::STORE_DEPTH)
    else $error("rotated read address beyond image store");

  // Frame end is only ever raised for an output request.
  a_eof_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_eof_q |-> !s1_load_q)
    else $error("frame end flagged on a load word");
`endif

endmodule

// ===== sv/imrot_store.sv =====
module imrot_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imrot_pkg::imrot_acc_t acc_i,
  input  logic [imrot_pkg::PIX_W-1:0] fill_i,
  output logic                  push_o,
  output imrot_pkg::imrot_res_t res_o
);

  logic [imrot_pkg::PIX_W-1:0] mem [imrot_pkg::STORE_DEPTH];
  logic [imrot_pkg::PIX_W-1:0] rd_q;
  logic                        s3_valid_q, s3_inside_q, s3_eof_q;

  // Single port: a load writes, a request inside the image reads.
  always_ff @(posedge clk_i) begin
    if (acc_i.valid && acc_i.is_load) begin
      mem[acc_i.addr] <= acc_i.pixel;
    end else if (acc_i.valid && acc_i.in_image) begin
      rd_q <= mem[acc_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= acc_i.valid && !acc_i.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_inside_q <= acc_i.in_image;
    s3_eof_q    <= acc_i.eof;
  end

  assign push_o      = s3_valid_q;
  assign res_o.pixel = s3_inside_q ? rd_q : fill_i;
  assign res_o.eof   = s3_eof_q;

endmodule

// ===== sv/imrot_out_fifo.sv =====
module imrot_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_accept_i,
  output logic                  room_o,
  input  logic                  push_i,
  input  imrot_pkg::imrot_res_t push_data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output imrot_pkg::imrot_res_t data_o
);

  localparam int DEPTH = imrot_pkg::OFIFO_DEPTH;
  localparam int PTR_W = imrot_pkg::OFIFO_PTR_W;
  localparam int CNT_W = imrot_pkg::OFIFO_CNT_W;

  imrot_pkg::imrot_res_t buf_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] cnt_d, cnt_q, outst_d, outst_q;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rd_ptr_q];
  // Requests in flight plus queued words never exceed the queue depth.
  assign room_o  = outst_q != CNT_W'(DEPTH);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
    outst_d  = outst_q + CNT_W'(req_accept_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      outst_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      outst_q  <= outst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != CNT_W'(DEPTH))
    else $error("output queue written while full");

  a_queued_le_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= outst_q)
    else $error("more queued words than outstanding requests");
`endif

endmodule

// ===== sv/image_rotation_fixed_point_unit.sv =====
// Image rotation about the centre by inverse mapping, in Q10 fixed point.
// A word with action 0 writes its pixel into the 160 x 128 image store at
// the next load position (raster order, wrapping to the start after the last
// entry); it gives no result. A word with action 1 takes the next output
// raster position, rotates it back into the source image with the sine and
// cosine registers, and returns the stored pixel there, or the fill colour
// when the source column or row is zero or below, or at or beyond the
// image size. The last position of each frame carries end_of_frame. A
// result passes, after its request is accepted, four register stages: the
// product stage, the coordinate and address stage, the registered read of
// the single-port image store and the output queue. The queue holds four
// words and keeps a place for every output request from acceptance until
// its word is collected, so input ready falls, for loads as well, while
// four requests are outstanding. Loads are taken one per clock cycle while
// input ready is high; a steady stream of output requests is taken while
// earlier ones are still in flight, up to four outstanding. The store is
// not cleared after reset and must be loaded before it is read. Registers
// are written through the configuration channel, which is always ready;
// the user must write them only while the block is idle; it is not enforced.
module image_rotation_fixed_point_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  imrot_in_if.sink           in_if,
  imrot_out_if.source        out_if,
  imrot_cfg_if.sink          cfg_if
);

  imrot_pkg::imrot_cfg_t cfg;
  imrot_pkg::imrot_acc_t acc;
  imrot_pkg::imrot_res_t res, out_res;
  logic                  in_accept, req_accept, push, room;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = room;
  assign in_accept    = in_if.valid && in_if.ready;
  assign req_accept   = in_accept && (in_if.action == imrot_pkg::ACT_OUTPUT);

  // Register file for the rotation coefficients and the fill colour.
  imrot_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_if.valid && cfg_if.ready),
    .wr_idx_i  (cfg_if.index),
    .wr_data_i (cfg_if.data),
    .cfg_o     (cfg)
  );

  // Raster and load counters, then the two coordinate stages.
  imrot_mapper u_mapper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .action_i (in_if.action),
    .pixel_i  (in_if.pixel_value),
    .cfg_i    (cfg),
    .acc_o    (acc)
  );

  // Image store with its registered read and the fill selection.
  imrot_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .fill_i (cfg.fill),
    .push_o (push),
    .res_o  (res)
  );

  // Output queue, with a count of requests not yet collected.
  imrot_out_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_accept_i (req_accept),
    .room_o       (room),
    .push_i       (push),
    .push_data_i  (res),
    .valid_o      (out_if.valid),
    .ready_i      (out_if.ready),
    .data_o       (out_res)
  );

  assign out_if.out_pixel    = out_res.pixel;
  assign out_if.end_of_frame = out_res.eof;

endmodule
